// ===== design/glfg_pkg.sv =====
// Package for the GPU load frequency governor: widths, codes, register
// defaults and the structs passed between its modules.
// No dependencies.
package glfg_pkg;

   localparam int FREQ_BITS = 20;
   localparam int TICK_BITS = 16;

   // Field widths fixed by the interface.
   localparam int LOAD_BITS  = 7;
   localparam int BUSY_BITS  = 16;
   localparam int HIST_BITS  = 8;
   localparam int CURF_BITS  = 20;
   localparam int REQ_BITS   = 24;
   localparam int DLN_BITS   = 16;

   // Widths actually carried inside the block.
   localparam int CUR_BITS  = (FREQ_BITS < CURF_BITS) ? FREQ_BITS : CURF_BITS;
   localparam int POLL_BITS = (TICK_BITS < 16) ? TICK_BITS : 16;

   // Divide by ten as a multiply by a rounded-up reciprocal; exact for any
   // product of PROD_BITS bits with this shift.
   localparam int PROD_BITS = CUR_BITS + LOAD_BITS;
   localparam int DIV_SHIFT = PROD_BITS + 4;
   localparam int MUL_BITS  = DIV_SHIFT - 3;
   localparam int QUO_BITS  = PROD_BITS - 3;
   localparam longint unsigned DIV_MUL = ((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10;

   localparam logic [REQ_BITS-1:0]  REQ_MAX   = {REQ_BITS{1'b1}};
   localparam logic [LOAD_BITS-1:0] PCT_LIMIT = LOAD_BITS'(100);

   // Register defaults.
   localparam logic [LOAD_BITS-1:0] UP_RESET   = LOAD_BITS'(95);
   localparam logic [LOAD_BITS-1:0] DOWN_RESET = LOAD_BITS'(75);
   localparam logic [HIST_BITS-1:0] HIST_RESET = HIST_BITS'(10);
   localparam logic [POLL_BITS-1:0] POLL_RESET = POLL_BITS'(75);
   localparam logic [DLN_BITS-1:0]  DLN_RESET  = DLN_BITS'(16);

   // Configuration port.
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Result queue.
   localparam int OUTQ_DEPTH    = 4;
   localparam int OUTQ_PTR_BITS = 2;
   localparam int OUTQ_CNT_BITS = 3;

   typedef enum logic [1:0] {
      KIND_ACTIVE = 2'd0,
      KIND_FRAME  = 2'd1,
      KIND_TICK   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      REG_HIGH_LOAD_PCT  = 3'd0,
      REG_LOW_LOAD_PCT   = 3'd1,
      REG_HISTORY_LENGTH = 3'd2,
      REG_POLL_TICKS     = 3'd3,
      REG_FRAME_DEADLINE = 3'd4,
      REG_FREQ_MAXIMUM   = 3'd5,
      REG_FREQ_MINIMUM   = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [LOAD_BITS-1:0] high_load_pct;
      logic [LOAD_BITS-1:0] low_load_pct;
      logic [HIST_BITS-1:0] history_length;
      logic [POLL_BITS-1:0] poll_ticks;
      logic [DLN_BITS-1:0]  frame_deadline;
      logic [CUR_BITS-1:0]  freq_maximum;
      logic [CUR_BITS-1:0]  freq_minimum;
   } cfg_type;

   // Outcome of one event: up to two requests, either of which may be the
   // scaled request still to be divided by ten.
   typedef struct packed {
      logic [1:0]           count;
      logic [REQ_BITS-1:0]  val0;
      logic [REQ_BITS-1:0]  val1;
      logic                 scaled0;
      logic                 scaled1;
      logic [PROD_BITS-1:0] product;
   } res_type;

   typedef struct packed {
      logic [REQ_BITS-1:0] freq;
      logic                last;
   } entry_type;

endpackage

// ===== design/glfg_csr.sv =====
// Configuration registers of the GPU load frequency governor behind an
// APB-style port, with range clamping on write.
// Depends on glfg_pkg.
module glfg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [glfg_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [glfg_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [glfg_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output glfg_pkg::cfg_type                   cfg,
   output logic                                cfg_clear
);

   glfg_pkg::cfg_type       cfg_ff;
   glfg_pkg::cfg_type       cfg_in;
   glfg_pkg::reg_index_type idx;
   logic                    wr;
   logic [glfg_pkg::LOAD_BITS-1:0] pct;
   logic [glfg_pkg::HIST_BITS-1:0] hist;
   logic [glfg_pkg::POLL_BITS-1:0] poll;
   logic [glfg_pkg::DLN_BITS-1:0]  dln;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = glfg_pkg::reg_index_type'(csr_paddr[4:2]);

   // Thresholds saturate at 100; counts and times of zero become one.
   assign pct  = (csr_pwdata[6:0] > glfg_pkg::PCT_LIMIT) ? glfg_pkg::PCT_LIMIT
                                                        : csr_pwdata[6:0];
   assign hist = (csr_pwdata[7:0] == '0) ? glfg_pkg::HIST_BITS'(1) : csr_pwdata[7:0];
   assign poll = (csr_pwdata[glfg_pkg::POLL_BITS-1:0] == '0) ? glfg_pkg::POLL_BITS'(1)
                                                              : csr_pwdata[glfg_pkg::POLL_BITS-1:0];
   assign dln  = (csr_pwdata[15:0] == '0) ? glfg_pkg::DLN_BITS'(1) : csr_pwdata[15:0];

   always_comb begin
      cfg_in    = cfg_ff;
      cfg_clear = 1'b0;
      if (wr) begin
         cfg_clear = 1'b1;
         unique case (idx)
            glfg_pkg::REG_HIGH_LOAD_PCT:  cfg_in.high_load_pct  = pct;
            glfg_pkg::REG_LOW_LOAD_PCT:   cfg_in.low_load_pct   = pct;
            glfg_pkg::REG_HISTORY_LENGTH: cfg_in.history_length = hist;
            glfg_pkg::REG_POLL_TICKS:     cfg_in.poll_ticks     = poll;
            glfg_pkg::REG_FRAME_DEADLINE: cfg_in.frame_deadline = dln;
            glfg_pkg::REG_FREQ_MAXIMUM:
               cfg_in.freq_maximum = csr_pwdata[glfg_pkg::CUR_BITS-1:0];
            glfg_pkg::REG_FREQ_MINIMUM:
               cfg_in.freq_minimum = csr_pwdata[glfg_pkg::CUR_BITS-1:0];
            default: cfg_clear = 1'b0;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         glfg_pkg::REG_HIGH_LOAD_PCT:
            csr_prdata = glfg_pkg::CSR_DATA_BITS'(cfg_ff.high_load_pct);
         glfg_pkg::REG_LOW_LOAD_PCT:
            csr_prdata = glfg_pkg::CSR_DATA_BITS'(cfg_ff.low_load_pct);
         glfg_pkg::REG_HISTORY_LENGTH:
            csr_prdata = glfg_pkg::CSR_DATA_BITS'(cfg_ff.history_length);
         glfg_pkg::REG_POLL_TICKS:
            csr_prdata = glfg_pkg::CSR_DATA_BITS'(cfg_ff.poll_ticks);
         glfg_pkg::REG_FRAME_DEADLINE:
            csr_prdata = glfg_pkg::CSR_DATA_BITS'(cfg_ff.frame_deadline);
         glfg_pkg::REG_FREQ_MAXIMUM:
            csr_prdata = glfg_pkg::CSR_DATA_BITS'(cfg_ff.freq_maximum);
         glfg_pkg::REG_FREQ_MINIMUM:
            csr_prdata = glfg_pkg::CSR_DATA_BITS'(cfg_ff.freq_minimum);
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_load_pct  <= glfg_pkg::UP_RESET;
         cfg_ff.low_load_pct   <= glfg_pkg::DOWN_RESET;
         cfg_ff.history_length <= glfg_pkg::HIST_RESET;
         cfg_ff.poll_ticks     <= glfg_pkg::POLL_RESET;
         cfg_ff.frame_deadline <= glfg_pkg::DLN_RESET;
         cfg_ff.freq_maximum   <= '0;
         cfg_ff.freq_minimum   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/glfg_eval.sv =====
// Event evaluation of the GPU load frequency governor: polling state, the
// low-load counter, the predictor and the registered outcome of each event.
// Depends on glfg_pkg.
module glfg_eval (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_vld,
   input  logic [1:0]                     in_kind,
   input  logic [glfg_pkg::LOAD_BITS-1:0] in_load,
   input  logic [glfg_pkg::BUSY_BITS-1:0] in_busy,
   input  logic [glfg_pkg::CUR_BITS-1:0]  in_cur,
   input  glfg_pkg::cfg_type              cfg,
   input  logic                           cfg_clear,
   input  logic                           room,
   output logic                           in_take,
   output logic                           mid_vld,
   output glfg_pkg::res_type              res
);

   logic                           polling_ff, polling_in;
   logic [glfg_pkg::HIST_BITS-1:0] count_ff, count_in;
   logic [glfg_pkg::TICK_BITS-1:0] countdown_ff, countdown_in;
   logic                           mid_vld_ff, mid_vld_in;
   glfg_pkg::res_type              res_ff, res_in;

   glfg_pkg::kind_type             kind;
   logic                           fire;
   logic                           run_pred;
   logic                           p_busy, p_up, p_down, p_sc;
   logic [glfg_pkg::HIST_BITS-1:0] cnt_tmp;
   logic [glfg_pkg::REQ_BITS-1:0]  fmax, fmin;
   logic [glfg_pkg::TICK_BITS-1:0] reload;

   assign kind    = glfg_pkg::kind_type'(in_kind);
   assign fire    = in_vld & (~mid_vld_ff | room);
   assign in_take = fire;
   assign fmax    = glfg_pkg::REQ_BITS'(cfg.freq_maximum);
   assign fmin    = glfg_pkg::REQ_BITS'(cfg.freq_minimum);
   assign reload  = glfg_pkg::TICK_BITS'(cfg.poll_ticks);

   // Predictor terms; a missed deadline clears the count before the load test.
   assign p_busy  = in_busy > cfg.frame_deadline;
   assign p_up    = in_load >= cfg.high_load_pct;
   assign p_down  = in_load <= cfg.low_load_pct;
   assign cnt_tmp = p_busy ? '0 : count_ff;
   assign p_sc    = ~p_up & p_down & (cnt_tmp == cfg.history_length);

   always_comb begin
      polling_in   = polling_ff;
      count_in     = count_ff;
      countdown_in = countdown_ff;
      run_pred     = 1'b0;

      res_in.count   = 2'd0;
      res_in.val0    = fmax;
      res_in.val1    = fmax;
      res_in.scaled0 = 1'b0;
      res_in.scaled1 = 1'b0;
      res_in.product = glfg_pkg::PROD_BITS'(in_cur) * glfg_pkg::PROD_BITS'(in_load);

      case (kind)
         glfg_pkg::KIND_ACTIVE: begin
            if (!polling_ff) begin
               res_in.count = 2'd1;
               count_in     = '0;
               polling_in   = 1'b1;
               countdown_in = reload;
            end
         end
         glfg_pkg::KIND_FRAME: begin
            if (polling_ff) begin
               countdown_in = reload;
            end
            run_pred = 1'b1;
         end
         glfg_pkg::KIND_TICK: begin
            if (polling_ff) begin
               if (countdown_ff > glfg_pkg::TICK_BITS'(1)) begin
                  countdown_in = countdown_ff - glfg_pkg::TICK_BITS'(1);
               end else if (in_busy == '0) begin
                  // Idle at timeout: drop to the minimum and stop polling.
                  res_in.count = 2'd1;
                  res_in.val0  = fmin;
                  count_in     = '0;
                  polling_in   = 1'b0;
                  countdown_in = '0;
               end else begin
                  run_pred     = 1'b1;
                  countdown_in = reload;
               end
            end
         end
         default: ;
      endcase

      if (run_pred) begin
         res_in.count   = {1'b0, p_busy} + {1'b0, p_up | p_sc};
         res_in.scaled0 = ~p_busy & p_sc;
         res_in.scaled1 = p_busy & p_sc;
         if (p_up || p_sc || !p_down) begin
            count_in = '0;
         end else begin
            count_in = cnt_tmp + glfg_pkg::HIST_BITS'(1);
         end
      end

      if (!fire) begin
         polling_in   = polling_ff;
         count_in     = count_ff;
         countdown_in = countdown_ff;
         res_in       = res_ff;
      end
      if (cfg_clear) begin
         count_in = '0;
      end

      mid_vld_in = fire | (mid_vld_ff & ~room);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         polling_ff   <= 1'b0;
         count_ff     <= '0;
         countdown_ff <= '0;
         mid_vld_ff   <= 1'b0;
      end else begin
         polling_ff   <= polling_in;
         count_ff     <= count_in;
         countdown_ff <= countdown_in;
         mid_vld_ff   <= mid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign mid_vld = mid_vld_ff;
   assign res     = res_ff;

endmodule

// ===== design/glfg_scale.sv =====
// Divide-by-ten and saturation of the scaled request, and forming of the
// queue entries with their last flags.
// Depends on glfg_pkg.
module glfg_scale (
   input  glfg_pkg::res_type   res,
   output glfg_pkg::entry_type entry0,
   output glfg_pkg::entry_type entry1
);

   localparam int FULL_BITS = glfg_pkg::PROD_BITS + glfg_pkg::MUL_BITS;
   localparam int WIDE_BITS = glfg_pkg::QUO_BITS + glfg_pkg::REQ_BITS;

   logic [FULL_BITS-1:0]          full;
   logic [glfg_pkg::QUO_BITS-1:0] quo;
   logic [WIDE_BITS-1:0]          quo_wide;
   logic [glfg_pkg::REQ_BITS-1:0] scaled;

   assign full     = FULL_BITS'(res.product) * FULL_BITS'(glfg_pkg::DIV_MUL);
   assign quo      = full[FULL_BITS-1:glfg_pkg::DIV_SHIFT];
   assign quo_wide = WIDE_BITS'(quo);
   assign scaled   = (quo_wide > WIDE_BITS'(glfg_pkg::REQ_MAX)) ? glfg_pkg::REQ_MAX
                                                               : quo_wide[glfg_pkg::REQ_BITS-1:0];

   assign entry0.freq = res.scaled0 ? scaled : res.val0;
   assign entry0.last = (res.count == 2'd1);
   assign entry1.freq = res.scaled1 ? scaled : res.val1;
   assign entry1.last = 1'b1;

endmodule

// ===== design/glfg_outq.sv =====
// Four-entry result queue of the GPU load frequency governor; takes up to
// two requests a cycle and drives the result channel from its head.
// Depends on glfg_pkg.
module glfg_outq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          mid_vld,
   input  logic [1:0]                    push_count,
   input  glfg_pkg::entry_type           entry0,
   input  glfg_pkg::entry_type           entry1,
   output logic                          room,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [glfg_pkg::REQ_BITS-1:0] rsp_tdata,
   output logic                          rsp_tlast
);

   glfg_pkg::entry_type                mem_ff [glfg_pkg::OUTQ_DEPTH];
   logic [glfg_pkg::OUTQ_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [glfg_pkg::OUTQ_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [glfg_pkg::OUTQ_CNT_BITS-1:0] count_ff, count_in;
   logic [glfg_pkg::OUTQ_CNT_BITS-1:0] after_pop;
   logic [glfg_pkg::OUTQ_PTR_BITS-1:0] wr_next;
   logic                               pop, push;

   assign pop       = rsp_tvalid & rsp_tready;
   assign after_pop = count_ff - glfg_pkg::OUTQ_CNT_BITS'(pop);
   // Room for a two-request event after this cycle's transfer.
   assign room      = after_pop <= glfg_pkg::OUTQ_CNT_BITS'(glfg_pkg::OUTQ_DEPTH - 2);
   assign push      = mid_vld & room;
   assign wr_next   = wr_ptr_ff + glfg_pkg::OUTQ_PTR_BITS'(1);

   always_comb begin
      rd_ptr_in = rd_ptr_ff + glfg_pkg::OUTQ_PTR_BITS'(pop);
      wr_ptr_in = wr_ptr_ff;
      count_in  = after_pop;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + glfg_pkg::OUTQ_PTR_BITS'(push_count);
         count_in  = after_pop + glfg_pkg::OUTQ_CNT_BITS'(push_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= entry0;
      end
      if (push && push_count == 2'd2) begin
         mem_ff[wr_next] <= entry1;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = mem_ff[rd_ptr_ff].freq;
   assign rsp_tlast  = mem_ff[rd_ptr_ff].last;

endmodule

// ===== design/gpu_load_frequency_governor.sv =====
// GPU load frequency governor, top level.
// Path: an event transferred at the req side passes the input register, the
// outcome register and the result queue before its first request is offered.
// Throughput: one event per cycle while the result queue has room; results
// leave at one transfer per cycle, each request of an event taking one transfer.
// Reset (synchronous, active high) stops polling, clears the counters and queues.
module gpu_load_frequency_governor (
   input  logic        clock,
   input  logic        reset,

   // Event channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // load_percent [6:0], busy_ms [22:7],
                                    // current_freq [42:23], zero [47:43]
   input  logic [1:0]  req_tuser,   // kind [1:0]

   // Request channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // request_freq [23:0]
   output logic        rsp_tlast,

   // Configuration port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // The design is three register stages: the input register holding an
   // accepted event, the outcome register written by the evaluation logic
   // together with the governor state, and the result queue. Each stage
   // passes its content on as soon as the next stage has room, so the input
   // side keeps taking events while finished requests wait at the output.

   glfg_pkg::cfg_type              cfg;
   logic                           cfg_clear;
   glfg_pkg::res_type              res;
   glfg_pkg::entry_type            entry0, entry1;
   logic                           room, mid_vld, in_take;

   logic                           in_vld_ff, in_vld_in;
   logic [1:0]                     in_kind_ff;
   logic [glfg_pkg::LOAD_BITS-1:0] in_load_ff;
   logic [glfg_pkg::BUSY_BITS-1:0] in_busy_ff;
   logic [glfg_pkg::CUR_BITS-1:0]  in_cur_ff;
   logic                           req_xfer;

   // The input register is free when empty or when its event is evaluated in
   // this cycle.
   assign req_tready = ~in_vld_ff | in_take;
   assign req_xfer   = req_tvalid & req_tready;
   assign in_vld_in  = req_xfer | (in_vld_ff & ~in_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // Event payload; wider frequency bits beyond the carried width are dropped.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_kind_ff <= req_tuser;
         in_load_ff <= req_tdata[6:0];
         in_busy_ff <= req_tdata[22:7];
         in_cur_ff  <= req_tdata[23 +: glfg_pkg::CUR_BITS];
      end
   end

   glfg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg),
      .cfg_clear   (cfg_clear)
   );

   // Evaluation: decides the requests of an event and updates the polling
   // flag, the low-load count and the poll countdown in the same cycle.
   glfg_eval u_eval (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (in_vld_ff),
      .in_kind   (in_kind_ff),
      .in_load   (in_load_ff),
      .in_busy   (in_busy_ff),
      .in_cur    (in_cur_ff),
      .cfg       (cfg),
      .cfg_clear (cfg_clear),
      .room      (room),
      .in_take   (in_take),
      .mid_vld   (mid_vld),
      .res       (res)
   );

   // The scaled request (current frequency times load over ten) is finished
   // from the registered product on its way into the queue.
   glfg_scale u_scale (
      .res    (res),
      .entry0 (entry0),
      .entry1 (entry1)
   );

   glfg_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .mid_vld    (mid_vld),
      .push_count (res.count),
      .entry0     (entry0),
      .entry1     (entry1),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
